// ===== rtl/anagram_group_classifier_unit_macros.svh =====
// Assertion macros for the anagram group classifier.
`ifndef ANAGRAM_GROUP_CLASSIFIER_UNIT_MACROS_SVH
`define ANAGRAM_GROUP_CLASSIFIER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/agc_pkg.sv =====
`default_nettype none

package agc_pkg;

   localparam int MAX_LEN      = 64;
   localparam int MAX_GROUPS   = 64;
   localparam int ALPHABET     = 26;
   localparam int MAX_WORDS    = 4096;

   localparam int LETTER_W     = 5;
   localparam int COUNT_W      = 7;
   localparam int GROUP_ID_W   = 6;
   localparam int STATUS_W     = 2;
   localparam int WORD_INDEX_W = 12;

   localparam int LEN_W   = $clog2(MAX_LEN + 1);
   localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
   localparam int ROT_W   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int WORDS_W = $clog2(MAX_WORDS);

   localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET - 1);

   typedef logic [COUNT_W-1:0] count_type;
   typedef count_type [ALPHABET-1:0] signature_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_MATCH = 2'd0,
      STATUS_NEW   = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_LONG  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic shift;
      logic write;
   } cell_ctrl_type;

   typedef struct packed {
      logic                accept;
      logic [LETTER_W-1:0] letter;
      logic                has_letter;
      logic                new_batch;
      logic                clear;
   } bank_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/agc_ifs.sv =====
`default_nettype none

interface agc_req_if;
   logic                         valid;
   logic                         ready;
   logic [agc_pkg::LETTER_W-1:0] letter;
   logic                         has_letter;
   logic                         word_end;
   logic                         new_batch;

   modport source (output valid, letter, has_letter, word_end, new_batch, input ready);
   modport sink (input valid, letter, has_letter, word_end, new_batch, output ready);
endinterface

interface agc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [agc_pkg::GROUP_ID_W-1:0]   group_id;
   logic [agc_pkg::STATUS_W-1:0]     status;
   logic [agc_pkg::WORD_INDEX_W-1:0] word_index;

   modport source (output valid, group_id, status, word_index, input ready);
   modport sink (input valid, group_id, status, word_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/agc_count_bank.sv =====
`default_nettype none

module agc_count_bank (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire agc_pkg::bank_ctrl_type ctrl,
   output agc_pkg::signature_type      counts,
   output logic                        overflow
);

   localparam int LEN_W   = agc_pkg::LEN_W;
   localparam int COUNT_W = agc_pkg::COUNT_W;

   agc_pkg::signature_type counts_ff, counts_in;
   logic [LEN_W-1:0]       length_ff, length_in;
   logic                   overflow_ff, overflow_in;

   always_comb begin
      counts_in   = counts_ff;
      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (ctrl.clear) begin
         counts_in   = '0;
         length_in   = '0;
         overflow_in = 1'b0;
      end else if (ctrl.accept) begin
         if (ctrl.new_batch) begin
            counts_in   = '0;
            length_in   = '0;
            overflow_in = 1'b0;
         end
         if (ctrl.has_letter && (ctrl.letter <= agc_pkg::LAST_LETTER)) begin
            if (length_in >= LEN_W'(agc_pkg::MAX_LEN)) begin
               overflow_in = 1'b1;
            end else begin
               counts_in[ctrl.letter] = counts_in[ctrl.letter] + COUNT_W'(1);
               length_in              = length_in + LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff   <= '0;
         length_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         counts_ff   <= counts_in;
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
      end
   end

   assign counts   = counts_ff;
   assign overflow = overflow_ff;

endmodule

`default_nettype wire

// ===== rtl/agc_group_cell.sv =====
`default_nettype none

module agc_group_cell (
   input  wire logic                   clock,
   input  wire agc_pkg::cell_ctrl_type ctrl,
   input  wire agc_pkg::signature_type shift_in,
   input  wire agc_pkg::signature_type write_data,
   output agc_pkg::signature_type      sig
);

   agc_pkg::signature_type sig_ff, sig_in;

   always_comb begin
      sig_in = sig_ff;
      if (ctrl.write) begin
         sig_in = write_data;
      end else if (ctrl.shift) begin
         sig_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff <= sig_in;
   end

   assign sig = sig_ff;

endmodule

`default_nettype wire

// ===== rtl/anagram_group_classifier_unit.sv =====
// Anagram group classifier.
// Words arrive on req_ch one letter per item; an item with word_end set closes
// the word, and new_batch empties the group table and restarts word numbering
// before the item is taken. Each finished word gives one item on rsp_ch with
// its group, a status and its position in the batch.
// A letter item gives no result. A word end starts a lookup in which the group
// signatures rotate once round a ring of MAX_GROUPS cells past a single
// comparator, one cell a cycle; a word that is too long skips the rotation.
// The result is then loaded into the output register and offered on rsp_ch.
// req_ch.ready is low during the lookup and while the result is being loaded.
// A result waiting on rsp_ch does not block further letter items; the next
// word end waits in its final step until the output register is free, so a
// stalled receiver eventually holds off the input.
// Reset empties the group table, the letter counts and the word counter at
// once; no clearing pass is needed.
`default_nettype none

`include "anagram_group_classifier_unit_macros.svh"

module anagram_group_classifier_unit (
   input wire logic clock,
   input wire logic reset,
   agc_req_if.sink   req_ch,
   agc_rsp_if.source rsp_ch
);

   localparam int MAX_GROUPS   = agc_pkg::MAX_GROUPS;
   localparam int MAX_WORDS    = agc_pkg::MAX_WORDS;
   localparam int GCNT_W       = agc_pkg::GCNT_W;
   localparam int ROT_W        = agc_pkg::ROT_W;
   localparam int WORDS_W      = agc_pkg::WORDS_W;
   localparam int GROUP_ID_W   = agc_pkg::GROUP_ID_W;
   localparam int WORD_INDEX_W = agc_pkg::WORD_INDEX_W;

   agc_pkg::state_type  state_ff, state_in;
   logic [ROT_W-1:0]    rot_ff, rot_in;
   logic                found_ff, found_in;
   logic [ROT_W-1:0]    match_gid_ff, match_gid_in;
   logic [GCNT_W-1:0]   groups_used_ff, groups_used_in;
   logic [WORDS_W-1:0]  words_seen_ff, words_seen_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GROUP_ID_W-1:0]   rsp_group_id_ff, rsp_group_id_in;
   agc_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [WORD_INDEX_W-1:0] rsp_word_index_ff, rsp_word_index_in;

   logic req_ready;
   logic shift;
   logic insert;
   logic clear;
   logic head_match;
   logic table_full;

   agc_pkg::bank_ctrl_type bank_ctrl;
   agc_pkg::signature_type counts;
   logic                   overflow;
   agc_pkg::signature_type ring_sig [MAX_GROUPS];

   assign bank_ctrl.accept     = req_ch.valid && req_ready;
   assign bank_ctrl.letter     = req_ch.letter;
   assign bank_ctrl.has_letter = req_ch.has_letter;
   assign bank_ctrl.new_batch  = req_ch.new_batch;
   assign bank_ctrl.clear      = clear;

   agc_count_bank u_count_bank (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (bank_ctrl),
      .counts   (counts),
      .overflow (overflow)
   );

   // Cell zero always holds the group whose index equals the rotation count.
   for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_ring
      agc_pkg::cell_ctrl_type cell_ctrl;

      assign cell_ctrl.shift = shift;
      assign cell_ctrl.write = insert && (groups_used_ff == GCNT_W'(g));

      agc_group_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .shift_in   (ring_sig[(g + 1) % MAX_GROUPS]),
         .write_data (counts),
         .sig        (ring_sig[g])
      );
   end

   assign head_match = (ring_sig[0] == counts) && (GCNT_W'(rot_ff) < groups_used_ff);
   assign table_full = (groups_used_ff == GCNT_W'(MAX_GROUPS));

   always_comb begin
      state_in          = state_ff;
      rot_in            = rot_ff;
      found_in          = found_ff;
      match_gid_in      = match_gid_ff;
      groups_used_in    = groups_used_ff;
      words_seen_in     = words_seen_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_group_id_in   = rsp_group_id_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_word_index_in = rsp_word_index_ff;
      req_ready         = 1'b0;
      shift             = 1'b0;
      insert            = 1'b0;
      clear             = 1'b0;
      unique case (state_ff)
         agc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               if (req_ch.new_batch) begin
                  groups_used_in = '0;
                  words_seen_in  = '0;
               end
               if (req_ch.word_end) begin
                  state_in     = agc_pkg::ST_SEARCH;
                  rot_in       = '0;
                  found_in     = 1'b0;
                  match_gid_in = '0;
               end
            end
         end
         agc_pkg::ST_SEARCH: begin
            if (overflow) begin
               state_in = agc_pkg::ST_RESULT;
            end else begin
               shift = 1'b1;
               if (head_match) begin
                  found_in     = 1'b1;
                  match_gid_in = rot_ff;
               end
               if (rot_ff == ROT_W'(MAX_GROUPS - 1)) begin
                  state_in = agc_pkg::ST_RESULT;
                  rot_in   = '0;
               end else begin
                  rot_in = rot_ff + ROT_W'(1);
               end
            end
         end
         agc_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_word_index_in = WORD_INDEX_W'(words_seen_ff);
               clear             = 1'b1;
               state_in          = agc_pkg::ST_IDLE;
               if (words_seen_ff == WORDS_W'(MAX_WORDS - 1)) begin
                  words_seen_in = '0;
               end else begin
                  words_seen_in = words_seen_ff + WORDS_W'(1);
               end
               priority if (overflow) begin
                  rsp_status_in   = agc_pkg::STATUS_LONG;
                  rsp_group_id_in = '0;
               end else if (found_ff) begin
                  rsp_status_in   = agc_pkg::STATUS_MATCH;
                  rsp_group_id_in = GROUP_ID_W'(match_gid_ff);
               end else if (!table_full) begin
                  rsp_status_in   = agc_pkg::STATUS_NEW;
                  rsp_group_id_in = GROUP_ID_W'(groups_used_ff);
                  insert          = 1'b1;
                  groups_used_in  = groups_used_ff + GCNT_W'(1);
               end else begin
                  rsp_status_in   = agc_pkg::STATUS_FULL;
                  rsp_group_id_in = '0;
               end
            end
         end
         default: begin
            state_in = agc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= agc_pkg::ST_IDLE;
         rot_ff         <= '0;
         found_ff       <= 1'b0;
         groups_used_ff <= '0;
         words_seen_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rot_ff         <= rot_in;
         found_ff       <= found_in;
         groups_used_ff <= groups_used_in;
         words_seen_ff  <= words_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_gid_ff      <= match_gid_in;
      rsp_group_id_ff   <= rsp_group_id_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_word_index_ff <= rsp_word_index_in;
   end

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.group_id   = rsp_group_id_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.word_index = rsp_word_index_ff;

   `AGC_ASSERT_NOW(a_groups_bound, clock, reset, 1'b1, groups_used_ff <= GCNT_W'(MAX_GROUPS), "Group count exceeds the table size.")
   `AGC_ASSERT_NEXT(a_new_group_counted, clock, reset, insert, groups_used_ff == $past(groups_used_ff) + GCNT_W'(1), "A new group was not counted.")
   `AGC_ASSERT_NOW(a_ring_home, clock, reset, state_ff == agc_pkg::ST_RESULT, rot_ff == '0, "The signature ring is not back in place.")
   `AGC_ASSERT_NEXT(a_counts_held, clock, reset, state_ff == agc_pkg::ST_SEARCH, $stable(counts), "Letter counts changed during a lookup.")

endmodule

`default_nettype wire

// ===== test/agc_tb_pkg.sv =====
`timescale 1ns / 100ps

package agc_tb_pkg;

   typedef logic [agc_pkg::LETTER_W-1:0]     letter_code_type;
   typedef logic [agc_pkg::GROUP_ID_W-1:0]   group_id_type;
   typedef logic [agc_pkg::WORD_INDEX_W-1:0] word_index_type;

   typedef struct {
      group_id_type        group_id;
      agc_pkg::status_type status;
      word_index_type      word_index;
   } word_verdict_type;

   class anagram_scoreboard;
      agc_pkg::signature_type word_counts;
      int unsigned            word_length;
      bit                     word_too_long;
      agc_pkg::signature_type group_table [agc_pkg::MAX_GROUPS];
      int unsigned            groups_used;
      int unsigned            words_in_batch;
      word_verdict_type       pending_verdicts [$];
      int unsigned            mistakes;

      function new();
         clear_word();
         groups_used = 0;
         words_in_batch = 0;
         mistakes = 0;
      endfunction

      function void clear_word();
         word_counts = '0;
         word_length = 0;
         word_too_long = 1'b0;
      endfunction

      function void classify_item(input letter_code_type letter, input logic has_letter,
                                  input logic word_end, input logic new_batch);
         word_verdict_type verdict;
         bit found;
         int g;
         if (new_batch) begin
            groups_used = 0;
            words_in_batch = 0;
            clear_word();
         end
         if (has_letter && letter <= agc_pkg::LAST_LETTER) begin
            if (word_length >= agc_pkg::MAX_LEN) begin
               word_too_long = 1'b1;
            end else begin
               word_counts[letter] = word_counts[letter] + agc_pkg::count_type'(1);
               word_length++;
            end
         end
         if (!word_end) return;
         verdict.group_id = '0;
         found = 1'b0;
         if (word_too_long) begin
            verdict.status = agc_pkg::STATUS_LONG;
         end else begin
            for (g = 0; g < int'(groups_used) && !found; g++) begin
               if (group_table[g] == word_counts) begin
                  found = 1'b1;
                  verdict.group_id = group_id_type'(g);
               end
            end
            if (found) begin
               verdict.status = agc_pkg::STATUS_MATCH;
            end else if (groups_used < agc_pkg::MAX_GROUPS) begin
               group_table[groups_used] = word_counts;
               verdict.group_id = group_id_type'(groups_used);
               groups_used++;
               verdict.status = agc_pkg::STATUS_NEW;
            end else begin
               verdict.status = agc_pkg::STATUS_FULL;
            end
         end
         verdict.word_index = word_index_type'(words_in_batch % agc_pkg::MAX_WORDS);
         words_in_batch = (words_in_batch + 1) % agc_pkg::MAX_WORDS;
         pending_verdicts.insert(pending_verdicts.size(), verdict);
         clear_word();
      endfunction

      function void check_result(input group_id_type group_id,
                                 input logic [agc_pkg::STATUS_W-1:0] status,
                                 input word_index_type word_index);
         word_verdict_type verdict;
         if (pending_verdicts.size() == 0) begin
            $error("unexpected item: group_id %0d status %0d word_index %0d",
                   group_id, status, word_index);
            mistakes++;
            return;
         end
         verdict = pending_verdicts.pop_front();
         if (group_id !== verdict.group_id) begin
            $error("group_id: expected %0d, actual %0d", verdict.group_id, group_id);
            mistakes++;
         end
         if (status !== verdict.status) begin
            $error("status: expected %0d, actual %0d", verdict.status, status);
            mistakes++;
         end
         if (word_index !== verdict.word_index) begin
            $error("word_index: expected %0d, actual %0d", verdict.word_index, word_index);
            mistakes++;
         end
      endfunction
   endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CALM_FROM    = 1050;
   localparam int CYCLE_LIMIT  = 2000000;

   logic clock;
   logic reset;

   agc_req_if req_ch ();
   agc_rsp_if rsp_ch ();

   anagram_group_classifier_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   agc_tb_pkg::anagram_scoreboard sb = new();
   agc_tb_pkg::letter_code_type spelled [$];
   bit send_idle_on;
   bit take_idle_on;
   bit noise_on;
   int unsigned useful_items;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("anagram_group_classifier_unit regression: fail");
      $finish;
   end

   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (take_idle_on && $urandom_range(7, 0) == 0) begin
            stall = $urandom_range(15, 1);
            rsp_ch.ready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.group_id, rsp_ch.status, rsp_ch.word_index);
   end

   task automatic send_item(input agc_tb_pkg::letter_code_type letter, input logic has_letter,
                            input logic word_end, input logic new_batch);
      int gap;
      @(negedge clock);
      gap = 0;
      if (send_idle_on && $urandom_range(7, 0) == 0) gap = $urandom_range(15, 1);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.letter = letter;
      req_ch.has_letter = has_letter;
      req_ch.word_end = word_end;
      req_ch.new_batch = new_batch;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sb.classify_item(letter, has_letter, word_end, new_batch);
      if (word_end || (has_letter && letter <= agc_pkg::LAST_LETTER)) useful_items++;
   endtask

   function automatic void make_word(input int len, input int lo, input int hi);
      spelled.delete();
      repeat (len)
         spelled.insert(spelled.size(), agc_tb_pkg::letter_code_type'($urandom_range(hi, lo)));
   endfunction

   task automatic send_word(input bit fresh);
      int i;
      if (spelled.size() == 0) begin
         send_item(agc_tb_pkg::letter_code_type'($urandom_range(31, 0)), 1'b0, 1'b1, fresh);
      end else begin
         for (i = 0; i < spelled.size(); i++) begin
            if (noise_on && $urandom_range(19, 0) == 0) begin
               // An item with no letter, or with a code past the alphabet, changes nothing.
               if ($urandom_range(1, 0) == 0)
                  send_item(agc_tb_pkg::letter_code_type'($urandom_range(31, 0)),
                            1'b0, 1'b0, 1'b0);
               else
                  send_item(agc_tb_pkg::letter_code_type'($urandom_range(31, 26)),
                            1'b1, 1'b0, 1'b0);
            end
            send_item(spelled[i], 1'b1, i == spelled.size() - 1, fresh && i == 0);
         end
      end
   endtask

   initial begin
      int kind;
      int nwords;
      int base;
      int w;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.letter = '0;
      req_ch.has_letter = 1'b0;
      req_ch.word_end = 1'b0;
      req_ch.new_batch = 1'b0;
      send_idle_on = 1'b0;
      take_idle_on = 1'b0;
      noise_on = 1'b0;
      useful_items = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      send_item(5'd0, 1'b1, 1'b0, 1'b1);
      send_item(5'd1, 1'b1, 1'b1, 1'b0);
      send_item(5'd1, 1'b1, 1'b0, 1'b0);
      send_item(5'd0, 1'b1, 1'b1, 1'b0);
      send_item(5'd31, 1'b0, 1'b1, 1'b0);
      send_item(5'd25, 1'b1, 1'b1, 1'b0);
      send_item(5'd26, 1'b1, 1'b0, 1'b0);
      send_item(5'd31, 1'b1, 1'b0, 1'b0);
      send_item(5'd7, 1'b0, 1'b0, 1'b0);
      send_item(5'd25, 1'b1, 1'b1, 1'b0);
      send_item(5'd2, 1'b1, 1'b0, 1'b0);
      send_item(5'd3, 1'b1, 1'b0, 1'b0);
      send_item(5'd3, 1'b1, 1'b1, 1'b1);
      send_item(5'd16, 1'b0, 1'b1, 1'b1);
      send_item(5'd16, 1'b1, 1'b0, 1'b0);
      send_item(5'd16, 1'b1, 1'b1, 1'b0);
      send_item(5'd15, 1'b1, 1'b0, 1'b0);
      send_item(5'd8, 1'b1, 1'b1, 1'b0);

      // Batches either fill the table with short words or repeat anagrams of a few letters.
      // The last batches run with no idle cycles on either side.
      noise_on = 1'b1;
      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) begin
         kind = $urandom_range(9, 0);
         send_idle_on = (useful_items < CALM_FROM) && ($urandom_range(3, 0) != 0);
         take_idle_on = (useful_items < CALM_FROM) && ($urandom_range(3, 0) != 0);
         if ($urandom_range(3, 0) == 0) begin
            make_word($urandom_range(4, 1), 0, 25);
            foreach (spelled[k]) send_item(spelled[k], 1'b1, 1'b0, 1'b0);
         end
         nwords = (kind < 2) ? $urandom_range(90, 66) : $urandom_range(30, 8);
         base = $urandom_range(23, 0);
         for (w = 0; w < nwords; w++) begin
            if (kind < 2)
               make_word($urandom_range(3, 1), 0, 25);
            else if ($urandom_range(11, 0) == 0)
               make_word($urandom_range(67, 62), base, base + 2);
            else
               make_word($urandom_range(5, 0), base, base + 2);
            send_word(w == 0);
         end
      end

      send_idle_on = 1'b0;
      take_idle_on = 1'b0;
      noise_on = 1'b0;

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (agc_pkg::MAX_GROUPS + 8) @(posedge clock);
      if (sb.mistakes == 0 && sb.pending_verdicts.size() == 0) begin
         $display("anagram_group_classifier_unit regression: pass");
      end else begin
         $display("anagram_group_classifier_unit regression: fail");
      end
      $finish;
   end

endmodule
